/* rtl/ptt_pkg.sv */
// Shared types and constants of the periodic task timer bank.
// Used by ptt_cell, ptt_update and periodic_task_timer_bank_top; depends on nothing.

package ptt_pkg;

    localparam int PERIOD_W  = 31;
    localparam int PROCESS_W = 16;
    localparam int ELAPSED_W = 24;
    localparam int SLOT_W    = 4;
    localparam int RES_CNT_W = 5;
    localparam logic [RES_CNT_W-1:0] MAX_RES = 5'd16;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_RUN    = 3'd1,
        OP_PAUSE  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_TICK   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_FIRE   = 2'd1,
        KIND_NOFIRE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NO_TASK = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_TICK = 2'd1,
        ST_DONE = 2'd2
    } t_state;

    // One timer slot as held by a cell
    typedef struct packed {
        logic                 used;
        logic                 enabled;
        logic [PERIOD_W-1:0]  period;
        logic [PERIOD_W-1:0]  count;
        logic [PROCESS_W-1:0] process;
    } t_slot;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
        logic run;
        logic pause;
        logic drop;
    } t_cell_ctl;

    typedef struct packed {
        t_kind                kind;
        logic [SLOT_W-1:0]    slot_out;
        t_status              status;
        logic [PROCESS_W-1:0] fired_process;
        logic [ELAPSED_W-1:0] overshoot;
        logic                 last;
    } t_result;

endpackage

/* rtl/ptt_cell.sv */
// One timer cell of the ring: holds a slot and takes its neighbour's slot on shift.
// Depends on ptt_pkg.

module ptt_cell
    import ptt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_next,
    input  t_slot     i_load,
    output t_slot     o_slot
);

    logic                 r_used;
    logic                 r_enabled;
    logic [PERIOD_W-1:0]  r_period;
    logic [PERIOD_W-1:0]  r_count;
    logic [PROCESS_W-1:0] r_process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_enabled <= 1'b0;
        end else if (i_ctl.shift) begin
            r_used    <= i_next.used;
            r_enabled <= i_next.enabled;
        end else if (i_ctl.load) begin
            r_used    <= 1'b1;
            r_enabled <= i_load.enabled;
        end else if (i_ctl.run) begin
            r_enabled <= 1'b1;
        end else if (i_ctl.pause) begin
            r_enabled <= 1'b0;
        end else if (i_ctl.drop) begin
            r_used    <= 1'b0;
            r_enabled <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_period  <= i_next.period;
            r_count   <= i_next.count;
            r_process <= i_next.process;
        end else if (i_ctl.load) begin
            r_period  <= i_load.period;
            r_count   <= i_load.count;
            r_process <= i_load.process;
        end
    end

    assign o_slot = '{used: r_used, enabled: r_enabled, period: r_period,
                      count: r_count, process: r_process};

endmodule

/* rtl/ptt_update.sv */
// Shared countdown unit at the head of the ring: subtract, detect expiry, reload.
// Depends on ptt_pkg.

module ptt_update
    import ptt_pkg::*;
(
    input  t_slot                i_head,
    input  logic [ELAPSED_W-1:0] i_elapsed,
    output t_slot                o_next,
    output logic                 o_fire,
    output logic [ELAPSED_W-1:0] o_overshoot
);

    logic [PERIOD_W-1:0] w_elapsed_ext;
    logic                w_expired;

    assign w_elapsed_ext = PERIOD_W'(i_elapsed);
    assign w_expired     = i_head.count <= w_elapsed_ext;
    assign o_fire        = i_head.used && i_head.enabled && w_expired;
    // count fits in elapsed's width whenever it has expired
    assign o_overshoot   = i_elapsed - i_head.count[ELAPSED_W-1:0];

    always_comb begin
        o_next = i_head;
        if (i_head.used && i_head.enabled) begin
            if (w_expired) begin
                o_next.count = i_head.period;
            end else begin
                o_next.count = i_head.count - w_elapsed_ext;
            end
        end
    end

endmodule

/* rtl/periodic_task_timer_bank_top.sv */
// Periodic task timer bank: a ring of timer cells around one countdown unit.
// Depends on ptt_pkg, ptt_cell and ptt_update.
//
// Usage:
//   Input channel (i_s_*): one command item per handshake; tuser carries the op
//   (add, run, pause, remove, tick), tdata the slot, period, process, start flag
//   and elapsed time. Output channel (o_m_*): result items, tuser the kind,
//   tlast on the final result of each command item.
//   Add, run, pause and remove give one result in the register in the cycle after
//   acceptance; a new command is taken each cycle while the output drains.
//   A tick rotates the ring once: one slot passes the shared subtractor per
//   cycle while the ring is not stalled, then ST_DONE closes the result run,
//   and only after that is a new item taken.
//   Fires come out in slot order, at most 16 per tick; each is held until the
//   next fire is found or the ring turn ends, so the final one carries tlast.
//   Reset clears every slot to free and paused, and empties the output.
//   A stalled receiver holds the output register; the ring stops rotating only
//   when a fire has to leave and the output register is still full.

module periodic_task_timer_bank_top
    import ptt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // slot[3:0], period[34:4], process[50:35],
                                     // start_paused[51], elapsed[75:52], zero pad
    input  logic [2:0]  i_s_tuser,   // op[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // slot_out[3:0], status[5:4], fired_process[21:6],
                                     // overshoot[45:22], zero pad
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    // Input fields
    t_op                  w_op;
    logic [SLOT_W-1:0]    w_slot;
    logic [PERIOD_W-1:0]  w_period;
    logic [PROCESS_W-1:0] w_process;
    logic                 w_paused;
    logic [ELAPSED_W-1:0] w_elapsed;

    assign w_op      = t_op'(i_s_tuser);
    assign w_slot    = i_s_tdata[3:0];
    assign w_period  = i_s_tdata[34:4];
    assign w_process = i_s_tdata[50:35];
    assign w_paused  = i_s_tdata[51];
    assign w_elapsed = i_s_tdata[75:52];

    // Control and result registers
    t_state               r_state,   n_state;
    logic                 r_m_valid, n_m_valid;
    t_result              r_m,       n_m;
    logic                 r_pend_v,  n_pend_v;
    t_result              r_pend,    n_pend;
    logic [RES_CNT_W-1:0] r_n,       n_n;
    logic [IW-1:0]        r_idx,     n_idx;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;

    // Ring
    t_slot                w_slots [NUM_SLOTS];
    t_cell_ctl            w_ctl   [NUM_SLOTS];
    t_slot                w_upd_next;
    logic                 w_fire;
    logic [ELAPSED_W-1:0] w_over;
    logic [NUM_SLOTS-1:0] w_used;
    t_slot                w_load;

    // Command decode
    logic          w_accept;
    logic          w_out_free;
    logic [6:0]    w_slot_ext;
    logic [IW-1:0] w_slot_idx;
    logic          w_hit;
    logic          w_free_any;
    logic [IW-1:0] w_free_idx;
    logic [6:0]    w_free_ext;
    logic [6:0]    w_idx_ext;
    logic          w_shift;
    logic          w_report;
    logic          w_step;
    logic          w_do_load;
    logic          w_do_run;
    logic          w_do_pause;
    logic          w_do_drop;
    t_result       w_fire_res;

    genvar k;
    generate
        for (k = 0; k < NUM_SLOTS; k++) begin : g_cell
            if (k == NUM_SLOTS - 1) begin : g_tail
                ptt_cell u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_ctl  (w_ctl[k]),
                    .i_next (w_upd_next),
                    .i_load (w_load),
                    .o_slot (w_slots[k])
                );
            end else begin : g_body
                ptt_cell u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_ctl  (w_ctl[k]),
                    .i_next (w_slots[k+1]),
                    .i_load (w_load),
                    .o_slot (w_slots[k])
                );
            end
            assign w_used[k] = w_slots[k].used;
        end
    endgenerate

    ptt_update u_update (
        .i_head     (w_slots[0]),
        .i_elapsed  (r_elapsed),
        .o_next     (w_upd_next),
        .o_fire     (w_fire),
        .o_overshoot(w_over)
    );

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_slot_ext = 7'(w_slot);
    assign w_slot_idx = w_slot_ext[IW-1:0];
    assign w_hit      = (w_slot_ext < 7'(NUM_SLOTS)) && w_used[w_slot_idx];
    assign w_free_ext = 7'(w_free_idx);
    assign w_idx_ext  = 7'(r_idx);

    // Lowest free slot
    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!w_used[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IW'(i);
            end
        end
    end

    assign w_load = '{used: 1'b1, enabled: !w_paused, period: w_period,
                      count: w_period, process: w_process};

    assign w_do_load  = w_accept && (w_op == OP_ADD) && w_free_any;
    assign w_do_run   = w_accept && (w_op == OP_RUN) && w_hit;
    assign w_do_pause = w_accept && (w_op == OP_PAUSE) && w_hit;
    assign w_do_drop  = w_accept && (w_op == OP_REMOVE) && w_hit;

    assign w_report = w_fire && (r_n < MAX_RES);
    assign w_step   = !(w_report && r_pend_v && !w_out_free);
    assign w_shift  = (r_state == ST_TICK) && w_step;

    assign w_fire_res = '{kind: KIND_FIRE, slot_out: w_idx_ext[SLOT_W-1:0],
                          status: STAT_OK, fired_process: w_slots[0].process,
                          overshoot: w_over, last: 1'b0};

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_ctl[i].shift = w_shift;
            w_ctl[i].load  = w_do_load  && (w_free_idx == IW'(i));
            w_ctl[i].run   = w_do_run   && (w_slot_idx == IW'(i));
            w_ctl[i].pause = w_do_pause && (w_slot_idx == IW'(i));
            w_ctl[i].drop  = w_do_drop  && (w_slot_idx == IW'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_pend_v  <= 1'b0;
            r_n       <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_pend_v  <= n_pend_v;
            r_n       <= n_n;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m       <= n_m;
        r_pend    <= n_pend;
        r_elapsed <= n_elapsed;
    end

    always_comb begin
        n_state    = r_state;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m        = r_m;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_n        = r_n;
        n_idx      = r_idx;
        n_elapsed  = r_elapsed;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = w_out_free;
                if (w_accept) begin
                    unique case (w_op)
                        OP_ADD: begin
                            n_m_valid = 1'b1;
                            n_m = '{kind: KIND_ACK, slot_out: w_free_ext[SLOT_W-1:0],
                                    status: (w_free_any ? STAT_OK : STAT_FULL),
                                    fired_process: '0, overshoot: '0, last: 1'b1};
                            if (!w_free_any) begin
                                n_m.slot_out = '0;
                            end
                        end
                        OP_RUN, OP_PAUSE, OP_REMOVE: begin
                            n_m_valid = 1'b1;
                            n_m = '{kind: KIND_ACK, slot_out: w_slot,
                                    status: (w_hit ? STAT_OK : STAT_NO_TASK),
                                    fired_process: '0, overshoot: '0, last: 1'b1};
                        end
                        OP_TICK: begin
                            n_elapsed = w_elapsed;
                            n_idx     = '0;
                            n_n       = '0;
                            n_pend_v  = 1'b0;
                            n_state   = ST_TICK;
                        end
                        default: begin
                            // unused op: drop the item
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (w_step) begin
                    n_idx = r_idx + 1'b1;
                    if (w_report) begin
                        // release the held fire, hold the new one
                        if (r_pend_v) begin
                            n_m_valid = 1'b1;
                            n_m       = r_pend;
                        end
                        n_pend_v = 1'b1;
                        n_pend   = w_fire_res;
                        n_n      = r_n + 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    if (r_pend_v) begin
                        n_m      = r_pend;
                        n_m.last = 1'b1;
                    end else begin
                        n_m = '{kind: KIND_NOFIRE, slot_out: '0, status: STAT_OK,
                                fired_process: '0, overshoot: '0, last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m.kind;
    assign o_m_tlast  = r_m.last;
    assign o_m_tdata  = {2'b00, r_m.overshoot, r_m.fired_process, r_m.status,
                         r_m.slot_out};

    a_res_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= MAX_RES)
        else $error("fire count above limit");

    a_pend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK && r_pend_v) |-> (r_n != '0))
        else $error("held fire without count");

    a_full_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK && n_state == ST_DONE) |-> (r_idx == LAST_IDX))
        else $error("tick closed before full ring turn");

    a_cmd_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_tuser == OP_ADD || i_s_tuser == OP_RUN ||
                      i_s_tuser == OP_PAUSE || i_s_tuser == OP_REMOVE))
        |=> (o_m_tvalid && o_m_tlast && o_m_tuser == KIND_ACK))
        else $error("command gave no acknowledge");

endmodule
